>>> rtl/pps_pkg.sv
// Shared types, register indexes, codes and stream layout of the poll scheduler.
`default_nettype none

package pps_pkg;

   localparam int TASK_SLOTS_DEF = 4;
   localparam int TIME_WIDTH_DEF = 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] REG_TASK_COUNT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_ZERO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_ONE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_TWO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_THREE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFLINE_THRESH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFFLINE_SKIP   = 3'd6;

   localparam logic OP_SELECT   = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   typedef struct packed {
      logic [2:0]       task_count;
      logic [3:0][31:0] interval;
      logic [7:0]       threshold;
      logic [31:0]      skip;
   } pps_cfg_type;

   typedef struct packed {
      logic capture;
      logic clr;
      logic step;
      logic wake;
      logic upd;
      logic load;
   } pps_cmd_type;

   typedef struct packed {
      logic in_select;
      logic busy;
      logic last;
      logic out_free;
   } pps_sts_type;

endpackage

`default_nettype wire

>>> rtl/periodic_poll_scheduler_unit.sv
// Top level of the periodic poll scheduler.
//
//   port group  direction  content
//   req_*       in         select or completion item
//   rsp_*       out        one result per item
//   csr_*       in         register writes
//
// A select sweeps the task table twice (pick, then next wake time); a completion
// or a select while a poll is outstanding sweeps it once. Each sweep covers the
// enabled tasks, one entry a cycle, through wrap-safe time comparisons.
// Reset is synchronous; it restores the configuration registers and clears the task table.
// The next item is taken while a result waits in the output register; a
// stalled result holds the block only at the point of loading the next one.
`default_nettype none

module periodic_poll_scheduler_unit
   import pps_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF,
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // opcode[0], now[32:1], task_index[34:33], ok[35], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // granted[0], chosen_task[2:1], skipped[3], went_offline[4], wake_due[36:5]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   pps_cfg_type cfg;
   pps_cmd_type cmd;
   pps_sts_type sts;

   pps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pps_dp #(
      .TASK_SLOTS (TASK_SLOTS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

>>> rtl/pps_csr.sv
// Configuration register file of the poll scheduler.
`default_nettype none

module pps_csr
   import pps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output pps_cfg_type                cfg
);

   pps_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_TASK_COUNT:     cfg_in.task_count  = csr_wdata[2:0];
            REG_INTERVAL_ZERO:  cfg_in.interval[0] = csr_wdata;
            REG_INTERVAL_ONE:   cfg_in.interval[1] = csr_wdata;
            REG_INTERVAL_TWO:   cfg_in.interval[2] = csr_wdata;
            REG_INTERVAL_THREE: cfg_in.interval[3] = csr_wdata;
            REG_OFFLINE_THRESH: cfg_in.threshold   = csr_wdata[7:0];
            REG_OFFLINE_SKIP:   cfg_in.skip        = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.task_count <= 3'd4;
         cfg_ff.interval   <= {4{32'd1000}};
         cfg_ff.threshold  <= 8'd3;
         cfg_ff.skip       <= 32'd60000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/pps_ctrl.sv
// Sequencing state machine of the poll scheduler.
`default_nettype none

module pps_ctrl
   import pps_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_tvalid,
   output logic       req_tready,
   input  pps_sts_type sts,
   output pps_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_WAKE   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               cmd.clr     = 1'b1;
               if (sts.in_select && !sts.busy)
                  state_in = ST_SCAN;
               else if (sts.in_select)
                  state_in = ST_WAKE;
               else
                  state_in = ST_UPDATE;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.last)
               state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd  = 1'b1;
            cmd.clr  = 1'b1;
            state_in = ST_WAKE;
         end
         ST_WAKE: begin
            cmd.step = 1'b1;
            cmd.wake = 1'b1;
            if (sts.last)
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

endmodule

`default_nettype wire

>>> rtl/pps_dp.sv
// Task table, scan comparator, update logic and result register of the poll scheduler.
`default_nettype none

module pps_dp
   import pps_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF,
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  pps_cfg_type                cfg,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  pps_cmd_type                cmd,
   output pps_sts_type                sts
);

   localparam int TW = TIME_WIDTH;
   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

   function automatic logic before_f(input logic [TW-1:0] a, input logic [TW-1:0] b);
      logic [TW-1:0] d;
      d = a - b;
      return d[TW-1];
   endfunction

   logic [TW-1:0] due_ff [TASK_SLOTS];
   logic [TW-1:0] due_in [TASK_SLOTS];
   logic [7:0]    err_ff [TASK_SLOTS];
   logic [7:0]    err_in [TASK_SLOTS];
   logic [TW-1:0] skip_ff [TASK_SLOTS];
   logic [TW-1:0] skip_in [TASK_SLOTS];

   logic          busy_ff, busy_in;
   logic [IW-1:0] busy_task_ff, busy_task_in;

   logic          op_ff;
   logic [TW-1:0] now_ff;
   logic [1:0]    task_ff;
   logic          ok_ff;

   logic [IW-1:0] cnt_ff, cnt_in;
   logic          found_ff, found_in;
   logic [TW-1:0] best_ff, best_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;

   logic          granted_ff, granted_in;
   logic [1:0]    chosen_ff, chosen_in;
   logic          skipped_ff, skipped_in;
   logic          offline_ff, offline_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [7:0]    tc8, last8;
   logic [TW-1:0] elem;
   logic          take;
   logic [IW-1:0] b_idx, t_idx;
   logic [7:0]    err_inc;
   logic          comp_hit;
   logic [TW-1:0] intv_b, intv_t, skip_len;

   // enabled task range
   always_comb begin
      tc8 = 8'(cfg.task_count);
      if (tc8 == 8'd0)
         last8 = 8'd0;
      else if (tc8 > 8'(TASK_SLOTS))
         last8 = 8'(TASK_SLOTS - 1);
      else
         last8 = tc8 - 8'd1;
   end

   assign elem = due_ff[cnt_ff];

   always_comb begin
      if (cmd.wake)
         take = (cnt_ff == '0) || before_f(elem, best_ff);
      else
         take = !before_f(now_ff, elem) && (!found_ff || before_f(elem, best_ff));
   end

   assign b_idx    = best_idx_ff;
   assign t_idx    = IW'(task_ff);
   assign intv_b   = TW'(cfg.interval[2'(b_idx)]);
   assign intv_t   = TW'(cfg.interval[2'(t_idx)]);
   assign skip_len = TW'(cfg.skip);
   assign err_inc  = (err_ff[t_idx] == 8'hFF) ? 8'hFF : err_ff[t_idx] + 8'd1;
   assign comp_hit = busy_ff && (5'(task_ff) == 5'(busy_task_ff));

   always_comb begin
      due_in        = due_ff;
      err_in        = err_ff;
      skip_in       = skip_ff;
      busy_in       = busy_ff;
      busy_task_in  = busy_task_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      granted_in    = granted_ff;
      chosen_in     = chosen_ff;
      skipped_in    = skipped_ff;
      offline_in    = offline_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_tvalid_ff && rsp_tready)
         rsp_tvalid_in = 1'b0;

      if (cmd.capture) begin
         granted_in = 1'b0;
         chosen_in  = 2'd0;
         skipped_in = 1'b0;
         offline_in = 1'b0;
      end

      if (cmd.clr) begin
         cnt_in   = '0;
         found_in = 1'b0;
      end

      if (cmd.step) begin
         cnt_in = cnt_ff + IW'(1);
         if (take) begin
            found_in    = 1'b1;
            best_in     = elem;
            best_idx_in = cnt_ff;
         end
      end

      if (cmd.upd) begin
         if (op_ff == OP_SELECT) begin
            if (found_ff) begin
               chosen_in = 2'(b_idx);
               if (err_ff[b_idx] >= cfg.threshold && before_f(now_ff, skip_ff[b_idx])) begin
                  due_in[b_idx] = now_ff + intv_b;
                  skipped_in    = 1'b1;
               end else begin
                  granted_in   = 1'b1;
                  busy_in      = 1'b1;
                  busy_task_in = b_idx;
               end
            end
         end else if (comp_hit) begin
            if (ok_ff) begin
               err_in[t_idx] = 8'd0;
            end else begin
               err_in[t_idx] = err_inc;
               if (err_inc >= cfg.threshold) begin
                  skip_in[t_idx] = now_ff + skip_len;
                  offline_in     = 1'b1;
               end
            end
            due_in[t_idx] = now_ff + intv_t;
            busy_in       = 1'b0;
         end
      end

      if (cmd.load) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = {3'b000, 32'(best_ff), offline_ff, skipped_ff, chosen_ff, granted_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            due_ff[i]  <= '0;
            err_ff[i]  <= '0;
            skip_ff[i] <= '0;
         end
         busy_ff       <= 1'b0;
         busy_task_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         due_ff        <= due_in;
         err_ff        <= err_in;
         skip_ff       <= skip_in;
         busy_ff       <= busy_in;
         busy_task_ff  <= busy_task_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_tdata[0];
         now_ff  <= TW'(req_tdata[32:1]);
         task_ff <= req_tdata[34:33];
         ok_ff   <= req_tdata[35];
      end
      cnt_ff      <= cnt_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      granted_ff  <= granted_in;
      chosen_ff   <= chosen_in;
      skipped_ff  <= skipped_in;
      offline_ff  <= offline_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.in_select = (req_tdata[0] == OP_SELECT);
   assign sts.busy      = busy_ff;
   assign sts.last      = (8'(cnt_ff) == last8);
   assign sts.out_free  = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
